### hdl/lspp_pkg.sv
// Package for the laser scan polar-to-pixel core: item types, CORDIC state type,
// register index codes and the CORDIC arctangent table.
// No dependencies.
`timescale 1ns / 1ps

package lspp_pkg;

  localparam int CordicIters = 16;
  localparam int MaxBeams = 1024;
  localparam logic signed [19:0] CordicStart = 20'sd39797;
  localparam logic [16:0] Q16One = 17'd65536;

  localparam logic [13:0] ArcTable [CordicIters] = '{
    14'd8192, 14'd4836, 14'd2555, 14'd1297, 14'd651, 14'd326, 14'd163, 14'd81,
    14'd41, 14'd20, 14'd10, 14'd5, 14'd3, 14'd1, 14'd1, 14'd0
  };

  localparam logic [1:0] RegMinRange = 2'd0;
  localparam logic [1:0] RegMaxRange = 2'd1;
  localparam logic [1:0] RegAngleStart = 2'd2;
  localparam logic [1:0] RegAngleStep = 2'd3;

  typedef struct packed {
    logic [9:0] beam_index;
    logic [15:0] beam_range;
  } in_item_t;

  typedef struct packed {
    logic [8:0] pixel_x;
    logic [8:0] pixel_y;
    logic plotted;
  } out_item_t;

  typedef struct packed {
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic signed [16:0] z;
    logic [1:0] quad;
    logic [15:0] range;
    logic ok;
  } cord_t;

endpackage

### hdl/laser_scan_polar_to_pixel_core.sv
// Laser beam to image pixel core: angle stage, 16 CORDIC cells, scaling stages, a chain of
// clog2(IMAGE_SIZE) division cells and an output register with a one-item skid buffer.
// Throughput is one item per cycle; the whole pipeline holds only while the skid buffer is full.
// Reset is asynchronous and active low; it empties the pipeline and loads register defaults.
`timescale 1ns / 1ps

module laser_scan_polar_to_pixel_core import lspp_pkg::*; #(
  parameter int IMAGE_SIZE = 500
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o,
  input  logic      cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int QW = $clog2(IMAGE_SIZE);
  localparam int QXW = (QW > 9) ? QW : 9;
  localparam int LS = $clog2(IMAGE_SIZE + 3);
  localparam int SMW = 16 + LS;
  localparam int PW = 36 + LS;
  localparam int RW = 34 + QW;
  localparam logic [SMW-1:0] SizeU = SMW'(IMAGE_SIZE);
  localparam logic [SMW-1:0] SizeP2U = SMW'(IMAGE_SIZE + 2);
  localparam logic signed [PW-1:0] SizeS = PW'(IMAGE_SIZE);

  logic [15:0] min_q, max_q, start_q, step_q;
  logic [SMW-1:0] sm_q, sm2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= 16'd0;
      max_q <= 16'hFFFF;
      start_q <= 16'h8000;
      step_q <= 16'd64;
      sm_q <= '0;
      sm2_q <= '0;
    end else begin
      sm_q <= SMW'(max_q) * SizeU;
      sm2_q <= SMW'(max_q) * SizeP2U;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegMinRange: min_q <= cfg_wdata_i;
          RegMaxRange: max_q <= cfg_wdata_i;
          RegAngleStart: start_q <= cfg_wdata_i;
          RegAngleStep: step_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  logic pipe_en;
  logic sk_full_q;
  assign pipe_en = !sk_full_q;
  assign in_stall_o = sk_full_q;

  logic a_v_q, a_ok_q;
  logic [15:0] a_prod_q, a_range_q;
  logic [25:0] a_prod_full;
  logic a_ok_d;

  always_comb begin
    a_prod_full = 26'(in_item_i.beam_index) * 26'(step_q);
    a_ok_d = (17'(in_item_i.beam_index) < 17'(MaxBeams)) && (max_q != 16'd0) &&
             (in_item_i.beam_range >= min_q) && (in_item_i.beam_range <= max_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (pipe_en) begin
      a_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      a_prod_q <= a_prod_full[15:0];
      a_range_q <= in_item_i.beam_range;
      a_ok_q <= a_ok_d;
    end
  end

  cord_t c_st [CordicIters+1];
  logic c_v [CordicIters+1];
  logic [15:0] ang;

  always_comb begin
    ang = start_q + a_prod_q;
    c_st[0].x = CordicStart;
    c_st[0].y = '0;
    c_st[0].z = signed'({3'b000, ang[13:0]});
    c_st[0].quad = ang[15:14];
    c_st[0].range = a_range_q;
    c_st[0].ok = a_ok_q;
    c_v[0] = a_v_q;
  end

  for (genvar i = 0; i < CordicIters; i++) begin : g_cordic
    lspp_cordic_cell #(.ITER(i)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (pipe_en),
      .valid_i (c_v[i]),
      .st_i    (c_st[i]),
      .valid_o (c_v[i+1]),
      .st_o    (c_st[i+1])
    );
  end

  logic [16:0] xc, yc;
  logic signed [17:0] cx_d, sy_d;
  logic b_v_q, b_ok_q;
  logic [15:0] b_range_q;
  logic signed [17:0] b_c_q, b_s_q;

  always_comb begin
    cord_t last;
    last = c_st[CordicIters];
    if (last.x < 0) begin
      xc = '0;
    end else if (last.x > signed'({3'b000, Q16One})) begin
      xc = Q16One;
    end else begin
      xc = last.x[16:0];
    end
    if (last.y < 0) begin
      yc = '0;
    end else if (last.y > signed'({3'b000, Q16One})) begin
      yc = Q16One;
    end else begin
      yc = last.y[16:0];
    end
    case (last.quad)
      2'd0: begin
        cx_d = signed'({1'b0, xc});
        sy_d = signed'({1'b0, yc});
      end
      2'd1: begin
        cx_d = -signed'({1'b0, yc});
        sy_d = signed'({1'b0, xc});
      end
      2'd2: begin
        cx_d = -signed'({1'b0, xc});
        sy_d = -signed'({1'b0, yc});
      end
      default: begin
        cx_d = signed'({1'b0, yc});
        sy_d = -signed'({1'b0, xc});
      end
    endcase
  end

  logic c2_v_q, c2_ok_q;
  logic signed [34:0] c2_rc_q, c2_rs_q;
  logic d_v_q, d_ok_q;
  logic signed [PW-1:0] d_px_q, d_py_q;
  logic e_v_q, e_plot_q;
  logic [RW-1:0] e_rx_q, e_ry_q;

  logic signed [PW-1:0] hi, lo, numx, numy;
  logic inx, iny;

  always_comb begin
    hi = signed'(PW'({sm_q, 16'h0000}));
    lo = -signed'(PW'({sm2_q, 16'h0000}));
    numx = d_px_q + hi;
    numy = d_py_q + hi;
    inx = (d_px_q < hi) && (d_px_q > lo);
    iny = (d_py_q < hi) && (d_py_q > lo);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
      c2_v_q <= 1'b0;
      d_v_q <= 1'b0;
      e_v_q <= 1'b0;
    end else if (pipe_en) begin
      b_v_q <= c_v[CordicIters];
      c2_v_q <= b_v_q;
      d_v_q <= c2_v_q;
      e_v_q <= d_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      b_c_q <= cx_d;
      b_s_q <= sy_d;
      b_range_q <= c_st[CordicIters].range;
      b_ok_q <= c_st[CordicIters].ok;
      c2_rc_q <= 35'(signed'({1'b0, b_range_q})) * 35'(b_c_q);
      c2_rs_q <= 35'(signed'({1'b0, b_range_q})) * 35'(b_s_q);
      c2_ok_q <= b_ok_q;
      d_px_q <= PW'(c2_rc_q) * SizeS;
      d_py_q <= PW'(c2_rs_q) * SizeS;
      d_ok_q <= c2_ok_q;
      e_rx_q <= numx[PW-1] ? '0 : RW'(numx);
      e_ry_q <= numy[PW-1] ? '0 : RW'(numy);
      e_plot_q <= d_ok_q && inx && iny;
    end
  end

  logic dv [QW+1];
  logic dplot [QW+1];
  logic [RW-1:0] drx [QW+1];
  logic [RW-1:0] dry [QW+1];
  logic [QW-1:0] dqx [QW+1];
  logic [QW-1:0] dqy [QW+1];

  assign dv[0] = e_v_q;
  assign dplot[0] = e_plot_q;
  assign drx[0] = e_rx_q;
  assign dry[0] = e_ry_q;
  assign dqx[0] = '0;
  assign dqy[0] = '0;

  for (genvar j = 0; j < QW; j++) begin : g_div
    lspp_div_cell #(.QW(QW), .RW(RW), .BIT(QW - 1 - j)) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (pipe_en),
      .valid_i     (dv[j]),
      .max_range_i (max_q),
      .rx_i        (drx[j]),
      .ry_i        (dry[j]),
      .qx_i        (dqx[j]),
      .qy_i        (dqy[j]),
      .plot_i      (dplot[j]),
      .valid_o     (dv[j+1]),
      .rx_o        (drx[j+1]),
      .ry_o        (dry[j+1]),
      .qx_o        (dqx[j+1]),
      .qy_o        (dqy[j+1]),
      .plot_o      (dplot[j+1])
    );
  end

  logic fin_v;
  out_item_t fin;
  logic [QXW-1:0] qx_ext, qy_ext;

  always_comb begin
    fin_v = dv[QW];
    qx_ext = QXW'(dqx[QW]);
    qy_ext = QXW'(dqy[QW]);
    fin.plotted = dplot[QW];
    fin.pixel_x = dplot[QW] ? qx_ext[8:0] : 9'd0;
    fin.pixel_y = dplot[QW] ? qy_ext[8:0] : 9'd0;
  end

  logic out_v_q, out_ok;
  out_item_t out_q, sk_q;
  assign out_ok = !out_v_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sk_full_q <= 1'b0;
    end else if (out_ok) begin
      if (sk_full_q) begin
        out_v_q <= 1'b1;
        sk_full_q <= 1'b0;
      end else begin
        out_v_q <= fin_v;
      end
    end else if (pipe_en && fin_v) begin
      sk_full_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ok) begin
      out_q <= sk_full_q ? sk_q : fin;
    end else if (pipe_en && fin_v) begin
      sk_q <= fin;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o = out_q;

  a_skid_needs_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_full_q |-> out_v_q)
    else $error("skid buffer holds an item while the output register is empty");

  a_zero_when_missed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_q.plotted |-> out_q.pixel_x == 9'd0 && out_q.pixel_y == 9'd0)
    else $error("unplotted item carries a nonzero pixel");

  a_quotient_in_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_v && dplot[QW] |->
      {1'b0, dqx[QW]} < (QW+1)'(IMAGE_SIZE) && {1'b0, dqy[QW]} < (QW+1)'(IMAGE_SIZE))
    else $error("plotted pixel lies outside the image");

  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sk_full_q) |-> $past(out_v_q && out_stall_i))
    else $error("skid buffer filled while the output was free");

endmodule

### hdl/lspp_cordic_cell.sv
// One CORDIC rotation cell of the sine/cosine chain.
// Depends on lspp_pkg for the cell state type and the arctangent table.
`timescale 1ns / 1ps

module lspp_cordic_cell import lspp_pkg::*; #(
  parameter int ITER = 0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  cord_t st_i,
  output logic  valid_o,
  output cord_t st_o
);

  logic valid_q;
  cord_t st_q;
  cord_t st_d;
  logic signed [19:0] dx;
  logic signed [19:0] dy;
  logic signed [16:0] arc;

  always_comb begin
    dx = st_i.y >>> ITER;
    dy = st_i.x >>> ITER;
    arc = signed'({3'b000, ArcTable[ITER]});
    st_d = st_i;
    if (!st_i.z[16]) begin
      st_d.x = st_i.x - dx;
      st_d.y = st_i.y + dy;
      st_d.z = st_i.z - arc;
    end else begin
      st_d.x = st_i.x + dx;
      st_d.y = st_i.y - dy;
      st_d.z = st_i.z + arc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign valid_o = valid_q;
  assign st_o = st_q;

endmodule

### hdl/lspp_div_cell.sv
// One restoring-division cell: resolves a single quotient bit of both pixel axes.
// Depends on lspp_pkg only through the common import convention.
`timescale 1ns / 1ps

module lspp_div_cell import lspp_pkg::*; #(
  parameter int QW = 9,
  parameter int RW = 43,
  parameter int BIT = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [15:0]   max_range_i,
  input  logic [RW-1:0] rx_i,
  input  logic [RW-1:0] ry_i,
  input  logic [QW-1:0] qx_i,
  input  logic [QW-1:0] qy_i,
  input  logic          plot_i,
  output logic          valid_o,
  output logic [RW-1:0] rx_o,
  output logic [RW-1:0] ry_o,
  output logic [QW-1:0] qx_o,
  output logic [QW-1:0] qy_o,
  output logic          plot_o
);

  localparam logic [QW-1:0] BitMask = QW'(1) << BIT;

  logic valid_q;
  logic [RW-1:0] rx_q, rx_d, ry_q, ry_d, dsh;
  logic [QW-1:0] qx_q, qx_d, qy_q, qy_d;
  logic plot_q;

  always_comb begin
    dsh = RW'(max_range_i) << (17 + BIT);
    rx_d = rx_i;
    ry_d = ry_i;
    qx_d = qx_i;
    qy_d = qy_i;
    if (rx_i >= dsh) begin
      rx_d = rx_i - dsh;
      qx_d = qx_i | BitMask;
    end
    if (ry_i >= dsh) begin
      ry_d = ry_i - dsh;
      qy_d = qy_i | BitMask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rx_q <= rx_d;
      ry_q <= ry_d;
      qx_q <= qx_d;
      qy_q <= qy_d;
      plot_q <= plot_i;
    end
  end

  assign valid_o = valid_q;
  assign rx_o = rx_q;
  assign ry_o = ry_q;
  assign qx_o = qx_q;
  assign qy_o = qy_q;
  assign plot_o = plot_q;

endmodule
